FILE: hdl/rbs_pkg.sv
// Shared constants and types for the ray/box slab intersection block.
`timescale 1ns / 1ps
`default_nettype none
package rbs_pkg;
  localparam int FRAC_BITS = 16;
  localparam int DW = 32;
  // dividend is a 33-bit magnitude shifted up by the fraction bits
  localparam int QW = 33 + FRAC_BITS;
  localparam int TW = QW + 1;
  localparam int CFG_IW = 3;

  localparam logic [CFG_IW-1:0] REG_BOX_MIN_X = 3'd0;
  localparam logic [CFG_IW-1:0] REG_BOX_MIN_Y = 3'd1;
  localparam logic [CFG_IW-1:0] REG_BOX_MIN_Z = 3'd2;
  localparam logic [CFG_IW-1:0] REG_BOX_MAX_X = 3'd3;
  localparam logic [CFG_IW-1:0] REG_BOX_MAX_Y = 3'd4;
  localparam logic [CFG_IW-1:0] REG_BOX_MAX_Z = 3'd5;
  localparam logic [CFG_IW-1:0] REG_VOLUME_VISIBLE = 3'd6;

  typedef struct packed {
    logic [2:0][DW-1:0] o;
    logic [2:0][DW-1:0] d;
    logic [DW-1:0]      near_l;
    logic [DW-1:0]      far_l;
    logic               miss;
    logic [2:0]         zero;
    logic [2:0]         neg_lo;
    logic [2:0]         neg_hi;
  } side_t;
endpackage
`default_nettype wire

FILE: hdl/rbs_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module rbs_div (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic [rbs_pkg::QW-1:0]   dvd_in,
  input  wire logic [rbs_pkg::DW-1:0]   den_in,
  output logic      [rbs_pkg::QW-1:0]   q_out
);
  localparam int QW = rbs_pkg::QW;
  localparam int DW = rbs_pkg::DW;

  logic [DW-1:0] rem_s [1:QW];
  logic [QW-1:0] dvd_s [1:QW];
  logic [QW-1:0] quo_s [1:QW];
  logic [DW-1:0] den_s [1:QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DW-1:0] cur_rem;
    logic [QW-1:0] cur_dvd;
    logic [QW-1:0] cur_quo;
    logic [DW-1:0] cur_den;
    logic [DW:0]   trial;
    logic          ge;
    if (k == 0) begin : g_first
      assign cur_rem = '0;
      assign cur_dvd = dvd_in;
      assign cur_quo = '0;
      assign cur_den = den_in;
    end else begin : g_next
      assign cur_rem = rem_s[k];
      assign cur_dvd = dvd_s[k];
      assign cur_quo = quo_s[k];
      assign cur_den = den_s[k];
    end
    assign trial = {cur_rem, cur_dvd[QW-1]};
    assign ge = trial >= {1'b0, cur_den};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[k+1] <= ge ? DW'(trial - {1'b0, cur_den}) : trial[DW-1:0];
        dvd_s[k+1] <= {cur_dvd[QW-2:0], 1'b0};
        quo_s[k+1] <= {cur_quo[QW-2:0], ge};
        den_s[k+1] <= cur_den;
      end
    end
  end

  assign q_out = quo_s[QW];
endmodule
`default_nettype wire

FILE: hdl/ray_box_slab_intersect.sv
// Top level: ray against configured axis-aligned box, slab test, Q16.16.
// Pipeline from input transfer to the Q16.16 result:
//   input register, then 33 + FRAC_BITS divider stages and four compare/multiply stages.
// Throughput: one ray per cycle while the output is not stalled; the six pipelined dividers set the depth.
// A stall at the output freezes the whole pipeline; nothing is lost or repeated.
// Reset (rst, synchronous) clears valid bits and loads the box to [0,1]^3, visible.
`timescale 1ns / 1ps
`default_nettype none
module ray_box_slab_intersect (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic signed [31:0] origin_x,
  input  wire logic signed [31:0] origin_y,
  input  wire logic signed [31:0] origin_z,
  input  wire logic signed [31:0] dir_x,
  input  wire logic signed [31:0] dir_y,
  input  wire logic signed [31:0] dir_z,
  input  wire logic signed [31:0] near_limit,
  input  wire logic signed [31:0] far_limit,
  input  wire logic        skip_volumes,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             is_hit,
  output logic signed [31:0] hit_t,
  output logic signed [31:0] point_x,
  output logic signed [31:0] point_y,
  output logic signed [31:0] point_z
);
  localparam int F  = rbs_pkg::FRAC_BITS;
  localparam int QW = rbs_pkg::QW;
  localparam int TW = rbs_pkg::TW;
  localparam int DW = rbs_pkg::DW;
  localparam logic signed [TW-1:0] T_MIN = {1'b1, {(TW-1){1'b0}}};
  localparam logic signed [TW-1:0] T_MAX = {1'b0, {(TW-1){1'b1}}};

  // configuration
  logic [2:0][DW-1:0] box_min;
  logic [2:0][DW-1:0] box_max;
  logic               volume_visible;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      box_min <= '0;
      box_max <= {3{32'sd65536}};
      volume_visible <= 1'b1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        rbs_pkg::REG_BOX_MIN_X: box_min[0] <= cfg_data;
        rbs_pkg::REG_BOX_MIN_Y: box_min[1] <= cfg_data;
        rbs_pkg::REG_BOX_MIN_Z: box_min[2] <= cfg_data;
        rbs_pkg::REG_BOX_MAX_X: box_max[0] <= cfg_data;
        rbs_pkg::REG_BOX_MAX_Y: box_max[1] <= cfg_data;
        rbs_pkg::REG_BOX_MAX_Z: box_max[2] <= cfg_data;
        rbs_pkg::REG_VOLUME_VISIBLE: volume_visible <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic adv;
  assign adv = !out_valid || out_ready;
  assign in_ready = adv;

  // input stage: plane offsets, magnitudes, signs
  logic [2:0][DW-1:0] in_o, in_d;
  assign in_o = {origin_z, origin_y, origin_x};
  assign in_d = {dir_z, dir_y, dir_x};

  logic [2:0][QW-1:0] dvd_lo_n, dvd_hi_n;
  logic [2:0][DW-1:0] den_n;
  logic [2:0]         neg_lo_n, neg_hi_n, zero_n, inside_n;

  always_comb begin
    logic [32:0] lo_d, hi_d, lo_m, hi_m;
    for (int a = 0; a < 3; a++) begin
      lo_d = {box_min[a][DW-1], box_min[a]} - {in_o[a][DW-1], in_o[a]};
      hi_d = {box_max[a][DW-1], box_max[a]} - {in_o[a][DW-1], in_o[a]};
      lo_m = lo_d[32] ? 33'(~lo_d + 33'd1) : lo_d;
      hi_m = hi_d[32] ? 33'(~hi_d + 33'd1) : hi_d;
      dvd_lo_n[a] = {lo_m, {F{1'b0}}};
      dvd_hi_n[a] = {hi_m, {F{1'b0}}};
      den_n[a]    = in_d[a][DW-1] ? DW'(~in_d[a] + 32'd1) : in_d[a];
      neg_lo_n[a] = lo_d[32] ^ in_d[a][DW-1];
      neg_hi_n[a] = hi_d[32] ^ in_d[a][DW-1];
      zero_n[a]   = in_d[a] == '0;
      inside_n[a] = ($signed(in_o[a]) >= $signed(box_min[a])) &&
                    ($signed(in_o[a]) <= $signed(box_max[a]));
    end
  end

  rbs_pkg::side_t     s0_side;
  logic [2:0][QW-1:0] s0_dvd_lo, s0_dvd_hi;
  logic [2:0][DW-1:0] s0_den;
  logic               v0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (adv) begin
      v0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_side.o      <= in_o;
      s0_side.d      <= in_d;
      s0_side.near_l <= near_limit;
      s0_side.far_l  <= far_limit;
      s0_side.miss   <= !volume_visible || skip_volumes || |(zero_n & ~inside_n);
      s0_side.zero   <= zero_n;
      s0_side.neg_lo <= neg_lo_n;
      s0_side.neg_hi <= neg_hi_n;
      s0_dvd_lo      <= dvd_lo_n;
      s0_dvd_hi      <= dvd_hi_n;
      s0_den         <= den_n;
    end
  end

  // dividers, two per axis
  logic [2:0][QW-1:0] q_lo, q_hi;
  for (genvar a = 0; a < 3; a++) begin : g_axis
    rbs_div u_div_lo (.clk(clk), .en(adv), .dvd_in(s0_dvd_lo[a]), .den_in(s0_den[a]),
                      .q_out(q_lo[a]));
    rbs_div u_div_hi (.clk(clk), .en(adv), .dvd_in(s0_dvd_hi[a]), .den_in(s0_den[a]),
                      .q_out(q_hi[a]));
  end

  // side data and valid bits alongside the divider stages
  rbs_pkg::side_t side_p [1:QW];
  logic [QW:1]    vp;

  always_ff @(posedge clk) begin
    if (rst) begin
      vp <= '0;
    end else if (adv) begin
      vp <= {vp[QW-1:1], v0};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_p[1] <= s0_side;
      for (int k = 2; k <= QW; k++) side_p[k] <= side_p[k-1];
    end
  end

  // C1: signed distances, ordered per axis
  rbs_pkg::side_t        c1_side;
  logic                  v1;
  logic signed [TW-1:0]  c1_lo [3];
  logic signed [TW-1:0]  c1_hi [3];
  logic signed [TW-1:0]  lo_n [3];
  logic signed [TW-1:0]  hi_n [3];

  always_comb begin
    logic signed [TW-1:0] t0, t1;
    for (int a = 0; a < 3; a++) begin
      t0 = side_p[QW].neg_lo[a] ? TW'(-{1'b0, q_lo[a]}) : {1'b0, q_lo[a]};
      t1 = side_p[QW].neg_hi[a] ? TW'(-{1'b0, q_hi[a]}) : {1'b0, q_hi[a]};
      if (side_p[QW].zero[a]) begin
        lo_n[a] = T_MIN;
        hi_n[a] = T_MAX;
      end else if (t0 > t1) begin
        lo_n[a] = t1;
        hi_n[a] = t0;
      end else begin
        lo_n[a] = t0;
        hi_n[a] = t1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= vp[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c1_side <= side_p[QW];
      c1_lo   <= lo_n;
      c1_hi   <= hi_n;
    end
  end

  // C2: narrow the interval
  rbs_pkg::side_t       c2_side;
  logic                 v2;
  logic signed [TW-1:0] c2_tmin, c2_tmax;
  logic signed [TW-1:0] near_ext, far_ext, mx_a, mx_b, mn_a, mn_b;

  assign near_ext = TW'($signed(c1_side.near_l));
  assign far_ext  = TW'($signed(c1_side.far_l));
  assign mx_a = (c1_lo[0] > near_ext) ? c1_lo[0] : near_ext;
  assign mx_b = (c1_lo[2] > c1_lo[1]) ? c1_lo[2] : c1_lo[1];
  assign mn_a = (c1_hi[0] < far_ext) ? c1_hi[0] : far_ext;
  assign mn_b = (c1_hi[2] < c1_hi[1]) ? c1_hi[2] : c1_hi[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c2_side <= c1_side;
      c2_tmin <= (mx_b > mx_a) ? mx_b : mx_a;
      c2_tmax <= (mn_b < mn_a) ? mn_b : mn_a;
    end
  end

  // C3: hit decision and t * d magnitudes
  logic                 v3, c3_hit;
  logic [DW-1:0]        c3_t;
  logic [2:0][DW-1:0]   c3_o;
  logic [2:0]           c3_neg;
  logic [2:0][63:0]     c3_prod;
  logic [DW-1:0]        t32, t_mag;

  assign t32   = c2_tmin[DW-1:0];
  assign t_mag = t32[DW-1] ? DW'(~t32 + 32'd1) : t32;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    logic [DW-1:0] d_mag;
    if (adv) begin
      c3_hit <= !c2_side.miss && (c2_tmin <= c2_tmax);
      c3_t   <= t32;
      c3_o   <= c2_side.o;
      for (int a = 0; a < 3; a++) begin
        d_mag = c2_side.d[a][DW-1] ? DW'(~c2_side.d[a] + 32'd1) : c2_side.d[a];
        c3_prod[a] <= 64'(d_mag) * 64'(t_mag);
        c3_neg[a]  <= c2_side.d[a][DW-1] ^ t32[DW-1];
      end
    end
  end

  // C4: scale, add origin, saturate; output register
  logic [2:0][DW-1:0] pt_n;

  always_comb begin
    logic [63:0] p;
    logic signed [65:0] s, r;
    for (int a = 0; a < 3; a++) begin
      p = c3_prod[a] >> F;
      s = c3_neg[a] ? 66'(-$signed({2'b00, p})) : $signed({2'b00, p});
      r = $signed({{34{c3_o[a][DW-1]}}, c3_o[a]}) + s;
      if (r > 66'sd2147483647) pt_n[a] = 32'h7fff_ffff;
      else if (r < -66'sd2147483648) pt_n[a] = 32'h8000_0000;
      else pt_n[a] = r[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      is_hit  <= c3_hit;
      hit_t   <= c3_hit ? c3_t : '0;
      point_x <= c3_hit ? pt_n[0] : '0;
      point_y <= c3_hit ? pt_n[1] : '0;
      point_z <= c3_hit ? pt_n[2] : '0;
    end
  end

  // a miss carries all-zero payload
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !is_hit) |-> (hit_t == 0 && point_x == 0 && point_y == 0 && point_z == 0))
    else $error("miss result with nonzero payload");

  // a surviving interval starts no earlier than the near limit and ends no later than the far limit
  a_tmin_bound: assert property (@(posedge clk) disable iff (rst)
    (v2 && !c2_side.miss && c2_tmin <= c2_tmax) |->
      (c2_tmin >= TW'($signed(c2_side.near_l)) && c2_tmax <= TW'($signed(c2_side.far_l))))
    else $error("interval outside ray limits");

  // a stalled output freezes the C3 valid bit and hit flag
  a_stall_freeze: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> ($stable(v3) && $stable(c3_hit)))
    else $error("pipeline moved during stall");
endmodule
`default_nettype wire

FILE: verif/ray_box_slab_intersect_test.sv
// Self-checking testbench for the ray/box slab intersection block.
`timescale 1ns / 1ps
module ray_box_slab_intersect_test;
  localparam int LATENCY    = rbs_pkg::FRAC_BITS + 37;
  localparam int STALL_LIMIT = 20000;
  localparam int N_RANDOM   = 1560;
  localparam logic [2:0] REG_UNUSED_IDX = 3'd7;

  typedef struct {
    logic signed [31:0] o [3];
    logic signed [31:0] d [3];
    logic signed [31:0] near_l;
    logic signed [31:0] far_l;
    logic               skip;
  } ray_t;

  typedef struct {
    logic               hit;
    logic signed [31:0] t;
    logic signed [31:0] p [3];
  } hit_rec_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] origin_x = '0, origin_y = '0, origin_z = '0;
  logic signed [31:0] dir_x = '0, dir_y = '0, dir_z = '0;
  logic signed [31:0] near_limit = '0, far_limit = '0;
  logic skip_volumes = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic is_hit;
  logic signed [31:0] hit_t, point_x, point_y, point_z;

  ray_box_slab_intersect dut (.*);

  always #5 clk = ~clk;

  // model copy of the box registers
  logic signed [31:0] box_lo [3];
  logic signed [31:0] box_hi [3];
  logic               visible;

  ray_t     ray_q [$];
  hit_rec_t hit_q [$];

  int  mismatches = 0;
  int  results = 0;
  int  hits = 0;
  int  idle_cnt = 0;
  bit  done = 1'b0;
  bit  calm = 1'b0;     // no idling on either side
  int  hold_off = 0;    // receiver hold-off request, in cycles
  int  cfg_writes = 0;

  function automatic logic signed [64:0] slab_dist(logic signed [33:0] num,
                                                   logic signed [31:0] den);
    logic [63:0] mn, md, q;
    mn = num < 0 ? 64'(-num) : 64'(num);
    md = den < 0 ? 64'(-64'(den)) : 64'(den);
    q  = (mn << rbs_pkg::FRAC_BITS) / md;
    return ((num < 0) != (den < 0)) ? -$signed({1'b0, q}) : $signed({1'b0, q});
  endfunction

  function automatic logic signed [31:0] hit_coord(logic signed [31:0] o,
                                                   logic signed [31:0] d,
                                                   logic signed [31:0] t);
    logic [63:0] md, mt, p;
    logic signed [65:0] r;
    md = d < 0 ? 64'(-64'(d)) : 64'(d);
    mt = t < 0 ? 64'(-64'(t)) : 64'(t);
    p  = (md * mt) >> rbs_pkg::FRAC_BITS;
    r  = ((d < 0) != (t < 0)) ? 66'(o) - $signed({2'b0, p}) : 66'(o) + $signed({2'b0, p});
    if (r > 66'sd2147483647) r = 66'sd2147483647;
    if (r < -66'sd2147483648) r = -66'sd2147483648;
    return r[31:0];
  endfunction

  function automatic hit_rec_t trace_ray(ray_t r);
    hit_rec_t res;
    logic signed [64:0] tmin, tmax, t0, t1, s;
    bit hit;
    tmin = r.near_l;
    tmax = r.far_l;
    hit = visible && !r.skip;
    for (int a = 0; a < 3 && hit; a++) begin
      if (r.d[a] == 0) begin
        if (r.o[a] < box_lo[a] || r.o[a] > box_hi[a]) hit = 0;
      end else begin
        t0 = slab_dist(34'(box_lo[a]) - 34'(r.o[a]), r.d[a]);
        t1 = slab_dist(34'(box_hi[a]) - 34'(r.o[a]), r.d[a]);
        if (t0 > t1) begin
          s = t0; t0 = t1; t1 = s;
        end
        if (t0 > tmin) tmin = t0;
        if (t1 < tmax) tmax = t1;
      end
      if (tmin > tmax) hit = 0;
    end
    res.hit = hit;
    res.t = hit ? tmin[31:0] : '0;
    for (int a = 0; a < 3; a++) res.p[a] = hit ? hit_coord(r.o[a], r.d[a], tmin[31:0]) : '0;
    return res;
  endfunction

  // driver
  always @(posedge clk) begin
    ray_t r;
    bit   fired;
    if (!rst) begin
      fired = in_valid && in_ready;
      if (fired) void'(ray_q.pop_front());
      if ((!in_valid || fired) && ray_q.size() > 0
          && (calm || $urandom_range(99) >= 27)) begin
        r = ray_q[0];
        in_valid <= 1'b1;
        origin_x <= r.o[0]; origin_y <= r.o[1]; origin_z <= r.o[2];
        dir_x <= r.d[0]; dir_y <= r.d[1]; dir_z <= r.d[2];
        near_limit <= r.near_l; far_limit <= r.far_l;
        skip_volumes <= r.skip;
        hit_q = {hit_q, trace_ray(r)};
      end else if (fired) begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall generator
  int hold_cnt = 0;
  bit hold_taken = 1'b0;
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else if (hold_off > 0 && !hold_taken && hold_cnt == 0) begin
      hold_cnt <= hold_off;
      hold_taken <= 1'b1;
      out_ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ready <= (hold_cnt == 1);
    end else out_ready <= calm || ($urandom_range(99) >= 27);
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      results++;
      if (hit_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer");
      end else begin
        hit_rec_t e;
        e = hit_q.pop_front();
        if (is_hit) hits++;
        if (is_hit !== e.hit || hit_t !== e.t || point_x !== e.p[0] ||
            point_y !== e.p[1] || point_z !== e.p[2]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp hit=%0d t=%0d p=(%0d,%0d,%0d) got hit=%0d t=%0d p=(%0d,%0d,%0d)",
                     e.hit, e.t, e.p[0], e.p[1], e.p[2],
                     is_hit, hit_t, point_x, point_y, point_z);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || done || (in_valid && in_ready) || (out_valid && out_ready)
        || (cfg_valid && cfg_ready)) idle_cnt <= 0;
    else begin
      idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= STALL_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cfg_writes++;
    case (idx)
      rbs_pkg::REG_BOX_MIN_X, rbs_pkg::REG_BOX_MIN_Y, rbs_pkg::REG_BOX_MIN_Z:
        box_lo[idx] = val;
      rbs_pkg::REG_BOX_MAX_X, rbs_pkg::REG_BOX_MAX_Y, rbs_pkg::REG_BOX_MAX_Z:
        box_hi[idx - rbs_pkg::REG_BOX_MAX_X] = val;
      rbs_pkg::REG_VOLUME_VISIBLE: visible = val[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic drain();
    while (ray_q.size() != 0 || in_valid || hit_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic set_box(logic signed [31:0] lo, logic signed [31:0] hi, logic vis);
    for (int a = 0; a < 3; a++) begin
      write_reg(3'(rbs_pkg::REG_BOX_MIN_X + a), lo + $signed(32'($urandom_range(3)) <<< 14));
      write_reg(3'(rbs_pkg::REG_BOX_MAX_X + a), hi - $signed(32'($urandom_range(3)) <<< 14));
    end
    write_reg(rbs_pkg::REG_VOLUME_VISIBLE, {31'($urandom), vis});
  endtask

  function automatic logic signed [31:0] pick_val(int scale);
    case ($urandom_range(9))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return '0;
      3: return $urandom;
      default: return $signed($urandom_range(2 * scale)) - scale;
    endcase
  endfunction

  // mostly rays aimed through the box, some wild
  function automatic ray_t make_ray();
    ray_t r;
    bit aimed;
    aimed = $urandom_range(99) < 70;
    for (int a = 0; a < 3; a++) begin
      if (aimed) begin
        r.o[a] = $signed($urandom_range(6 << 16)) - (2 << 16);
        r.d[a] = $urandom_range(9) == 0 ? '0 : $signed($urandom_range(4 << 16)) - (2 << 16);
      end else begin
        r.o[a] = pick_val(1 << 20);
        r.d[a] = pick_val(1 << 18);
      end
    end
    case ($urandom_range(5))
      0: begin r.near_l = pick_val(1 << 20); r.far_l = pick_val(1 << 20); end
      1: begin r.near_l = 32'sh8000_0000; r.far_l = 32'sh7fff_ffff; end
      default: begin r.near_l = -$signed($urandom_range(1 << 16)); r.far_l = $urandom_range(1 << 22); end
    endcase
    r.skip = $urandom_range(19) == 0;
    return r;
  endfunction

  function automatic ray_t fixed_ray(logic signed [31:0] ox, logic signed [31:0] dx,
                                     logic signed [31:0] nl, logic signed [31:0] fl,
                                     logic sk);
    ray_t r;
    r.o[0] = ox; r.o[1] = 32'sh8000; r.o[2] = 32'sh8000;
    r.d[0] = dx; r.d[1] = '0; r.d[2] = '0;
    r.near_l = nl; r.far_l = fl; r.skip = sk;
    return r;
  endfunction

  initial begin
    for (int a = 0; a < 3; a++) begin
      box_lo[a] = '0;
      box_hi[a] = 32'sh1_0000;
    end
    visible = 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset box
    ray_q = {ray_q, fixed_ray(-32'sh1_0000, 32'sh1_0000, 0, 32'sh7fff_ffff, 0)};
    ray_q = {ray_q, fixed_ray(32'sh3_0000, -32'sh1_0000, 0, 32'sh7fff_ffff, 0)};
    ray_q = {ray_q, fixed_ray(-32'sh1_0000, 32'sh1_0000, 0, 32'sh7fff_ffff, 1)};
    ray_q = {ray_q, fixed_ray(32'sh8000, 0, 0, 32'sh10, 0)};
    ray_q = {ray_q, fixed_ray(32'sh2_0000, 0, 0, 32'sh10, 0)};
    ray_q = {ray_q, fixed_ray(-32'sh1_0000, 32'sh1_0000, 32'sh10, 0, 0)};
    ray_q = {ray_q, fixed_ray(32'sh8000_0000, 1, 32'sh8000_0000, 32'sh7fff_ffff, 0)};
    ray_q = {ray_q, fixed_ray(32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000,
                              32'sh7fff_ffff, 0)};
    ray_q = {ray_q, fixed_ray(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000,
                              32'sh7fff_ffff, 0)};
    ray_q = {ray_q, fixed_ray(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                              32'sh7fff_ffff, 0)};
    ray_q = {ray_q, fixed_ray(-1, 1, 32'sh8000_0000, 32'sh7fff_ffff, 0)};
    ray_q = {ray_q, fixed_ray(-32'sh1_0000, 32'sh4_0000, 32'sh7fff_ffff, 32'sh7fff_ffff, 0)};
    drain();

    // extreme box, inverted box, hidden volume
    write_reg(rbs_pkg::REG_BOX_MIN_X, 32'h8000_0000);
    write_reg(rbs_pkg::REG_BOX_MAX_X, 32'h7fff_ffff);
    write_reg(rbs_pkg::REG_BOX_MIN_Y, 32'h8000_0000);
    write_reg(rbs_pkg::REG_BOX_MAX_Y, 32'h7fff_ffff);
    write_reg(rbs_pkg::REG_BOX_MIN_Z, 32'h8000_0000);
    write_reg(rbs_pkg::REG_BOX_MAX_Z, 32'h7fff_ffff);
    ray_q = {ray_q, fixed_ray(0, 1, 32'sh8000_0000, 32'sh7fff_ffff, 0)};
    ray_q = {ray_q, fixed_ray(32'sh7fff_ffff, -1, 0, 32'sh7fff_ffff, 0)};
    ray_q = {ray_q, fixed_ray(32'sh8000_0000, 32'sh7fff_ffff, 0, 32'sh7fff_ffff, 0)};
    drain();
    write_reg(rbs_pkg::REG_BOX_MIN_X, 32'h2_0000);
    write_reg(rbs_pkg::REG_BOX_MAX_X, 32'h1_0000);
    ray_q = {ray_q, fixed_ray(0, 32'sh1_0000, 32'sh8000_0000, 32'sh7fff_ffff, 0)};
    ray_q = {ray_q, fixed_ray(32'sh1_8000, 0, 32'sh8000_0000, 32'sh7fff_ffff, 0)};
    drain();
    write_reg(rbs_pkg::REG_VOLUME_VISIBLE, 32'h0);
    ray_q = {ray_q, fixed_ray(-32'sh1_0000, 32'sh1_0000, 0, 32'sh7fff_ffff, 0)};
    drain();
    write_reg(REG_UNUSED_IDX, 32'hffff_ffff);
    set_box(0, 32'sh1_0000, 1);

    // long receiver hold-off while the sender keeps offering
    calm = 1'b1;
    for (int i = 0; i < 200; i++) ray_q = {ray_q, make_ray()};
    hold_off = 400;
    drain();
    calm = 1'b0;

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        1: set_box(-32'sh4_0000, 32'sh4_0000, 1);
        2: set_box(32'sh8000_0000, 32'sh7fff_ffff, 1);
        3: set_box(32'sh1_0000, -32'sh1_0000, 1);
        4: set_box(-32'sh100, 32'sh100, 0);
        5: set_box(-32'sh1_0000, 32'sh2_0000, 1);
        default: ;
      endcase
      calm = (ph == 2);
      for (int i = 0; i < N_RANDOM / 6; i++) ray_q = {ray_q, make_ray()};
      drain();
    end

    done = 1'b1;
    $display("covered %0d rays (%0d hits) over %0d register writes, incl. a %0d-cycle stall",
             results, hits, cfg_writes, 400);
    if (mismatches == 0) $display("PASS");
    else begin
      $display("%0d mismatches", mismatches);
      $display("FAIL");
    end
    $finish;
  end
endmodule
